[rtl/rv64x_pkg.sv]
// Shared types, opcodes and helpers for the RV64IM execute unit.
`default_nettype none
package rv64x_pkg;

  localparam int XLEN        = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_FENCE  = 7'h0F;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_OPIMMW = 7'h1B;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_OPW    = 7'h3B;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [5:0] SHI_SRA   = 6'h10;

  typedef enum logic [1:0] {
    KIND_DONE,
    KIND_MUL,
    KIND_DIV
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_FIX
  } back_state_t;

  typedef struct packed {
    logic [31:0] instruction;
    logic [63:0] pc_value;
    logic [63:0] rs1_value;
    logic [63:0] rs2_value;
    logic [63:0] load_data;
  } in_word_t;

  typedef struct packed {
    logic        rd_write;
    logic [4:0]  rd_index;
    logic [63:0] rd_value;
    logic [63:0] next_pc;
    logic [63:0] mem_address;
    logic        is_load;
    logic        is_store;
    logic [63:0] store_data;
    logic [1:0]  access_size_log2;
    logic        illegal;
    logic        system_request;
  } out_word_t;

  typedef struct packed {
    out_word_t   res;
    kind_t       kind;
    logic [2:0]  f3;
    logic        word;
    logic [63:0] a;
    logic [63:0] b;
  } dec_t;

  function automatic logic [63:0] sx32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

endpackage
`default_nettype wire

[rtl/rv64x_queue.sv]
// Short queue of decoded words between the front and back parts.
`default_nettype none
module rv64x_queue #(
  parameter int DEPTH = rv64x_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire rv64x_pkg::dec_t push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output rv64x_pkg::dec_t      pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  rv64x_pkg::dec_t  mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = do_push ? ((wp_r == LAST) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = do_pop ? ((rp_r == LAST) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

[rtl/rv64x_front.sv]
// Front part: decode, combinational execution and classification of mul/div words.
`default_nettype none
module rv64x_front (
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rv64x_pkg::in_word_t in_word,
  output logic               push_valid,
  input  wire logic          push_ready,
  output rv64x_pkg::dec_t    push_data
);

  logic [31:0] ins;
  logic [63:0] pc, a, b, ld;
  logic [6:0]  op, f7;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [63:0] immi, imms, immb, immu, immj;
  logic [63:0] npc, val, addr, sdata, pc4;
  logic        wr, ill, isl, iss, sys, tk, wordf;
  logic [1:0]  size;
  rv64x_pkg::kind_t kind;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  assign ins  = in_word.instruction;
  assign pc   = in_word.pc_value;
  assign a    = in_word.rs1_value;
  assign b    = in_word.rs2_value;
  assign ld   = in_word.load_data;
  assign op   = ins[6:0];
  assign rd   = ins[11:7];
  assign f3   = ins[14:12];
  assign f7   = ins[31:25];
  assign immi = {{52{ins[31]}}, ins[31:20]};
  assign imms = {{52{ins[31]}}, ins[31:25], ins[11:7]};
  assign immb = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign immu = {{32{ins[31]}}, ins[31:12], 12'b0};
  assign immj = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign pc4  = pc + 64'd4;

  always_comb begin
    npc   = pc4;
    val   = '0;
    addr  = '0;
    sdata = '0;
    wr    = 1'b0;
    ill   = 1'b0;
    isl   = 1'b0;
    iss   = 1'b0;
    sys   = 1'b0;
    tk    = 1'b0;
    wordf = 1'b0;
    size  = '0;
    kind  = rv64x_pkg::KIND_DONE;
    unique case (op)
      rv64x_pkg::OPC_LUI: begin
        val = immu;
        wr  = 1'b1;
      end
      rv64x_pkg::OPC_AUIPC: begin
        val = pc + immu;
        wr  = 1'b1;
      end
      rv64x_pkg::OPC_JAL: begin
        val = pc4;
        wr  = 1'b1;
        npc = pc + immj;
      end
      rv64x_pkg::OPC_JALR: begin
        if (f3 != 3'd0) begin
          ill = 1'b1;
        end else begin
          val = pc4;
          wr  = 1'b1;
          npc = (a + immi) & ~64'd1;
        end
      end
      rv64x_pkg::OPC_BRANCH: begin
        unique case (f3)
          3'd0: tk = (a == b);
          3'd1: tk = (a != b);
          3'd4: tk = ($signed(a) < $signed(b));
          3'd5: tk = ($signed(a) >= $signed(b));
          3'd6: tk = (a < b);
          3'd7: tk = (a >= b);
          default: ill = 1'b1;
        endcase
        if (tk) begin
          npc = pc + immb;
        end
      end
      rv64x_pkg::OPC_LOAD: begin
        if (f3 == 3'd7) begin
          ill = 1'b1;
        end else begin
          size = f3[1:0];
          addr = a + immi;
          isl  = 1'b1;
          wr   = 1'b1;
          unique case (f3)
            3'd0: val = {{56{ld[7]}}, ld[7:0]};
            3'd1: val = {{48{ld[15]}}, ld[15:0]};
            3'd2: val = {{32{ld[31]}}, ld[31:0]};
            3'd4: val = {56'd0, ld[7:0]};
            3'd5: val = {48'd0, ld[15:0]};
            3'd6: val = {32'd0, ld[31:0]};
            default: val = ld;
          endcase
        end
      end
      rv64x_pkg::OPC_STORE: begin
        if (f3[2]) begin
          ill = 1'b1;
        end else begin
          size  = f3[1:0];
          addr  = a + imms;
          sdata = b;
          iss   = 1'b1;
        end
      end
      rv64x_pkg::OPC_OPIMM: begin
        wr = 1'b1;
        unique case (f3)
          3'd0: val = a + immi;
          3'd1: begin
            if (ins[31:26] != 6'd0) ill = 1'b1;
            else val = a << ins[25:20];
          end
          3'd2: val = {63'd0, $signed(a) < $signed(immi)};
          3'd3: val = {63'd0, a < immi};
          3'd4: val = a ^ immi;
          3'd5: begin
            if (ins[31:26] == 6'd0) val = a >> ins[25:20];
            else if (ins[31:26] == rv64x_pkg::SHI_SRA) val = $signed(a) >>> ins[25:20];
            else ill = 1'b1;
          end
          3'd6: val = a | immi;
          default: val = a & immi;
        endcase
      end
      rv64x_pkg::OPC_OPIMMW: begin
        wr = 1'b1;
        if (f3 == 3'd0) begin
          val = rv64x_pkg::sx32(a + immi);
        end else if (f3 == 3'd1 && f7 == rv64x_pkg::F7_BASE) begin
          val = rv64x_pkg::sx32({32'd0, a[31:0] << ins[24:20]});
        end else if (f3 == 3'd5 && f7 == rv64x_pkg::F7_BASE) begin
          val = rv64x_pkg::sx32({32'd0, a[31:0] >> ins[24:20]});
        end else if (f3 == 3'd5 && f7 == rv64x_pkg::F7_ALT) begin
          val = rv64x_pkg::sx32({32'd0, $signed(a[31:0]) >>> ins[24:20]});
        end else begin
          ill = 1'b1;
        end
      end
      rv64x_pkg::OPC_OP: begin
        wr = 1'b1;
        if (f7 == rv64x_pkg::F7_MULDIV) begin
          kind = f3[2] ? rv64x_pkg::KIND_DIV : rv64x_pkg::KIND_MUL;
        end else if (f7 == rv64x_pkg::F7_BASE) begin
          unique case (f3)
            3'd0: val = a + b;
            3'd1: val = a << b[5:0];
            3'd2: val = {63'd0, $signed(a) < $signed(b)};
            3'd3: val = {63'd0, a < b};
            3'd4: val = a ^ b;
            3'd5: val = a >> b[5:0];
            3'd6: val = a | b;
            default: val = a & b;
          endcase
        end else if (f7 == rv64x_pkg::F7_ALT && f3 == 3'd0) begin
          val = a - b;
        end else if (f7 == rv64x_pkg::F7_ALT && f3 == 3'd5) begin
          val = $signed(a) >>> b[5:0];
        end else begin
          ill = 1'b1;
        end
      end
      rv64x_pkg::OPC_OPW: begin
        wr = 1'b1;
        if (f7 == rv64x_pkg::F7_MULDIV) begin
          wordf = 1'b1;
          if (f3[2]) kind = rv64x_pkg::KIND_DIV;
          else if (f3 == 3'd0) kind = rv64x_pkg::KIND_MUL;
          else ill = 1'b1;
        end else if (f7 == rv64x_pkg::F7_BASE && f3 == 3'd0) begin
          val = rv64x_pkg::sx32(a + b);
        end else if (f7 == rv64x_pkg::F7_ALT && f3 == 3'd0) begin
          val = rv64x_pkg::sx32(a - b);
        end else if (f7 == rv64x_pkg::F7_BASE && f3 == 3'd1) begin
          val = rv64x_pkg::sx32({32'd0, a[31:0] << b[4:0]});
        end else if (f7 == rv64x_pkg::F7_BASE && f3 == 3'd5) begin
          val = rv64x_pkg::sx32({32'd0, a[31:0] >> b[4:0]});
        end else if (f7 == rv64x_pkg::F7_ALT && f3 == 3'd5) begin
          val = rv64x_pkg::sx32({32'd0, $signed(a[31:0]) >>> b[4:0]});
        end else begin
          ill = 1'b1;
        end
      end
      rv64x_pkg::OPC_SYSTEM: sys = 1'b1;
      rv64x_pkg::OPC_FENCE: ;
      default: ill = 1'b1;
    endcase
    if (ill) begin
      wr   = 1'b0;
      isl  = 1'b0;
      iss  = 1'b0;
      npc  = pc;
      kind = rv64x_pkg::KIND_DONE;
    end
    if (rd == 5'd0) begin
      wr = 1'b0;
    end
  end

  always_comb begin
    push_data.res.rd_write         = wr;
    push_data.res.rd_index         = wr ? rd : 5'd0;
    push_data.res.rd_value         = wr ? val : 64'd0;
    push_data.res.next_pc          = npc;
    push_data.res.mem_address      = (isl || iss) ? addr : 64'd0;
    push_data.res.is_load          = isl;
    push_data.res.is_store         = iss;
    push_data.res.store_data       = iss ? sdata : 64'd0;
    push_data.res.access_size_log2 = (isl || iss) ? size : 2'd0;
    push_data.res.illegal          = ill;
    push_data.res.system_request   = sys;
    push_data.kind                 = kind;
    push_data.f3                   = f3;
    push_data.word                 = wordf;
    push_data.a                    = a;
    push_data.b                    = b;
  end

endmodule
`default_nettype wire

[rtl/rv64x_back.sv]
// Back part: sequenced multiply and divide, result register toward the output.
`default_nettype none
module rv64x_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  output logic                 q_ready,
  input  wire rv64x_pkg::dec_t q_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output rv64x_pkg::out_word_t out_word
);

  localparam int XL = rv64x_pkg::XLEN;
  localparam int CNTW = $clog2(XL);
  localparam logic [CNTW-1:0] DIV_LAST = CNTW'(XL - 1);
  localparam logic [CNTW-1:0] MUL_LAST = CNTW'(4);

  rv64x_pkg::back_state_t st_r, st_nxt;
  logic                   out_valid_r, out_valid_nxt;
  rv64x_pkg::out_word_t   out_r, out_nxt, res_r, res_nxt;
  logic [CNTW-1:0]        cnt_r, cnt_nxt;
  logic [2:0]             f3_r, f3_nxt;
  logic                   word_r, word_nxt;
  logic [XL-1:0]          wa_r, wa_nxt, wb_r, wb_nxt;
  logic [2*XL-1:0]        acc_r, acc_nxt, pp_sh;
  logic [XL-1:0]          pp_r, pp_nxt;
  logic [1:0]             ppi_r, ppi_nxt;
  logic [XL-1:0]          rem_r, rem_nxt, quo_r, quo_nxt, dv_r, dv_nxt, dnd_r, dnd_nxt;
  logic                   na_r, na_nxt, nb_r, nb_nxt, dz_r, dz_nxt;
  logic [XL:0]            rsh, dif;
  logic [XL-1:0]          a_ext, b_ext, hi, qf, rf, vf;
  logic                   sgn, out_free;

  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    sgn   = !q_data.f3[0];
    a_ext = q_data.word ? (sgn ? rv64x_pkg::sx32(q_data.a) : {32'd0, q_data.a[31:0]})
                        : q_data.a;
    b_ext = q_data.word ? (sgn ? rv64x_pkg::sx32(q_data.b) : {32'd0, q_data.b[31:0]})
                        : q_data.b;
    unique case (ppi_r)
      2'd0: pp_sh = {64'd0, pp_r};
      2'd3: pp_sh = {pp_r, 64'd0};
      default: pp_sh = {32'd0, pp_r, 32'd0};
    endcase
    rsh = {rem_r, quo_r[XL-1]};
    dif = rsh - {1'b0, dv_r};
    hi  = acc_r[2*XL-1:XL];
    qf  = (!f3_r[0] && (na_r != nb_r)) ? -quo_r : quo_r;
    rf  = (!f3_r[0] && na_r) ? -rem_r : rem_r;
    if (dz_r) begin
      qf = '1;
      rf = dnd_r;
    end
    vf = '0;
    if (f3_r[2]) begin
      vf = f3_r[1] ? rf : qf;
    end else begin
      unique case (f3_r[1:0])
        2'd0: vf = acc_r[XL-1:0];
        2'd1: vf = hi - (wa_r[XL-1] ? wb_r : '0) - (wb_r[XL-1] ? wa_r : '0);
        2'd2: vf = hi - (wa_r[XL-1] ? wb_r : '0);
        default: vf = hi;
      endcase
    end
    if (word_r) begin
      vf = rv64x_pkg::sx32(vf);
    end
  end

  always_comb begin
    st_nxt        = st_r;
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    out_nxt       = out_r;
    res_nxt       = res_r;
    cnt_nxt       = cnt_r;
    f3_nxt        = f3_r;
    word_nxt      = word_r;
    wa_nxt        = wa_r;
    wb_nxt        = wb_r;
    acc_nxt       = acc_r;
    pp_nxt        = pp_r;
    ppi_nxt       = ppi_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dv_nxt        = dv_r;
    dnd_nxt       = dnd_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    dz_nxt        = dz_r;
    q_ready       = 1'b0;
    unique case (st_r)
      rv64x_pkg::BK_IDLE: begin
        if (q_valid) begin
          res_nxt  = q_data.res;
          f3_nxt   = q_data.f3;
          word_nxt = q_data.word;
          cnt_nxt  = '0;
          unique case (q_data.kind)
            rv64x_pkg::KIND_MUL: begin
              q_ready = 1'b1;
              wa_nxt  = q_data.a;
              wb_nxt  = q_data.b;
              acc_nxt = '0;
              st_nxt  = rv64x_pkg::BK_MUL;
            end
            rv64x_pkg::KIND_DIV: begin
              q_ready = 1'b1;
              na_nxt  = sgn && a_ext[XL-1];
              nb_nxt  = sgn && b_ext[XL-1];
              quo_nxt = (sgn && a_ext[XL-1]) ? -a_ext : a_ext;
              dv_nxt  = (sgn && b_ext[XL-1]) ? -b_ext : b_ext;
              dz_nxt  = (b_ext == '0);
              dnd_nxt = a_ext;
              rem_nxt = '0;
              st_nxt  = rv64x_pkg::BK_DIV;
            end
            default: begin
              if (out_free) begin
                q_ready       = 1'b1;
                out_nxt       = q_data.res;
                out_valid_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      rv64x_pkg::BK_MUL: begin
        pp_nxt  = (cnt_r[1] ? wa_r[XL-1:XL/2] : wa_r[XL/2-1:0]) *
                  (cnt_r[0] ? wb_r[XL-1:XL/2] : wb_r[XL/2-1:0]);
        ppi_nxt = cnt_r[1:0];
        if (cnt_r != '0) begin
          acc_nxt = acc_r + pp_sh;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) begin
          st_nxt = rv64x_pkg::BK_FIX;
        end
      end
      rv64x_pkg::BK_DIV: begin
        if (!dif[XL]) begin
          rem_nxt = dif[XL-1:0];
        end else begin
          rem_nxt = rsh[XL-1:0];
        end
        quo_nxt = {quo_r[XL-2:0], !dif[XL]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          st_nxt = rv64x_pkg::BK_FIX;
        end
      end
      default: begin
        if (out_free) begin
          out_nxt          = res_r;
          out_nxt.rd_value = res_r.rd_write ? vf : '0;
          out_valid_nxt    = 1'b1;
          st_nxt           = rv64x_pkg::BK_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= rv64x_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    res_r  <= res_nxt;
    cnt_r  <= cnt_nxt;
    f3_r   <= f3_nxt;
    word_r <= word_nxt;
    wa_r   <= wa_nxt;
    wb_r   <= wb_nxt;
    acc_r  <= acc_nxt;
    pp_r   <= pp_nxt;
    ppi_r  <= ppi_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dv_r   <= dv_nxt;
    dnd_r  <= dnd_nxt;
    na_r   <= na_nxt;
    nb_r   <= nb_nxt;
    dz_r   <= dz_nxt;
  end

endmodule
`default_nettype wire

[rtl/rv64im_execute_unit.sv]
// Top level of the RV64IM execute unit: front decode, queue, back sequencer.
//
//   channel | ports                        | word
//   input   | in_valid, in_ready, in_word  | in_word_t
//   result  | out_valid, out_ready, out_word | out_word_t
//
// Non-M instructions pass through the back part at one word per cycle while the output is not stalled.
// Multiply words occupy the back sequencer while it forms and sums four 32x32 partial products.
// Divide and remainder words occupy it while it forms one quotient bit per cycle.
// The queue lets the front keep accepting, until the queue is full, while the back works or the output stalls.
// Reset (rst_n low, synchronous) empties the queue and the result register.
`default_nettype none
module rv64im_execute_unit #(
  parameter int QUEUE_DEPTH = rv64x_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rv64x_pkg::in_word_t in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rv64x_pkg::out_word_t     out_word
);

  rv64x_pkg::dec_t push_data, pop_data;
  logic            push_valid, push_ready, pop_valid, pop_ready;

  rv64x_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rv64x_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rv64x_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_data    (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  a_ill_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.illegal |->
      !out_word.rd_write && !out_word.is_load && !out_word.is_store)
    else $error("illegal word carries side effects");

  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.rd_write |-> out_word.rd_value == 64'd0 &&
      out_word.rd_index == 5'd0)
    else $error("unused destination fields not cleared");

  a_ls_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.is_load && out_word.is_store))
    else $error("load and store both set");

endmodule
`default_nettype wire

[sim/rv64im_execute_unit_tb.sv]
// Testbench for the RV64IM execute unit: random and directed words against a predictor.
module rv64im_execute_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] MSB = 64'h8000_0000_0000_0000;
  localparam int CYCLE_LIMIT = 900000;

  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] shr_arith(input logic [63:0] x, input int sh);
    return $signed(x) >>> sh;
  endfunction

  function automatic logic [63:0] div_signed(input logic [63:0] a, input logic [63:0] b,
                                             input bit want_rem);
    logic [63:0] ma, mb, q, r;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    if (b == 0) return want_rem ? a : '1;
    q = ma / mb;
    r = ma % mb;
    if (want_rem) return a[63] ? -r : r;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic logic [63:0] div_signed32(input logic [31:0] x, input logic [31:0] y,
                                               input bit want_rem);
    logic [31:0] ma, mb, q, r;
    ma = x[31] ? -x : x;
    mb = y[31] ? -y : y;
    if (y == 0) return want_rem ? sext32(x) : '1;
    q = ma / mb;
    r = ma % mb;
    if (want_rem) return sext32(x[31] ? -r : r);
    return sext32((x[31] != y[31]) ? -q : q);
  endfunction

  function automatic rv64x_pkg::out_word_t execute_insn(input rv64x_pkg::in_word_t w);
    rv64x_pkg::out_word_t o;
    logic [31:0] ins;
    logic [63:0] pc, a, b, ld, immi, imms, immb, immu, immj, npc, val, addr, sdata;
    logic [127:0] prod;
    logic [6:0] op, f7;
    logic [4:0] rd;
    logic [2:0] f3;
    logic [5:0] sh6;
    logic [4:0] sh5;
    logic [1:0] size;
    bit wr, ill, isl, iss, sys, tk;
    ins = w.instruction; pc = w.pc_value; a = w.rs1_value; b = w.rs2_value; ld = w.load_data;
    op = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12]; f7 = ins[31:25];
    sh6 = ins[25:20]; sh5 = ins[24:20];
    immi = {{52{ins[31]}}, ins[31:20]};
    imms = {{52{ins[31]}}, ins[31:25], ins[11:7]};
    immb = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    immu = {{32{ins[31]}}, ins[31:12], 12'h0};
    immj = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    npc = pc + 64'd4; val = 0; addr = 0; sdata = 0; size = 0;
    wr = 0; ill = 0; isl = 0; iss = 0; sys = 0; tk = 0;
    case (op)
      rv64x_pkg::OPC_LUI: begin val = immu; wr = 1; end
      rv64x_pkg::OPC_AUIPC: begin val = pc + immu; wr = 1; end
      rv64x_pkg::OPC_JAL: begin val = npc; wr = 1; npc = pc + immj; end
      rv64x_pkg::OPC_JALR: begin
        if (f3 != 0) ill = 1;
        else begin val = npc; wr = 1; npc = (a + immi) & ~64'h1; end
      end
      rv64x_pkg::OPC_BRANCH: begin
        case (f3)
          3'd0: tk = a == b;
          3'd1: tk = a != b;
          3'd4: tk = $signed(a) < $signed(b);
          3'd5: tk = $signed(a) >= $signed(b);
          3'd6: tk = a < b;
          3'd7: tk = a >= b;
          default: ill = 1;
        endcase
        if (tk) npc = pc + immb;
      end
      rv64x_pkg::OPC_LOAD: begin
        if (f3 == 7) ill = 1;
        else begin
          size = f3[1:0]; addr = a + immi; isl = 1; wr = 1;
          case (size)
            2'd0: val = f3[2] ? {56'h0, ld[7:0]} : {{56{ld[7]}}, ld[7:0]};
            2'd1: val = f3[2] ? {48'h0, ld[15:0]} : {{48{ld[15]}}, ld[15:0]};
            2'd2: val = f3[2] ? {32'h0, ld[31:0]} : sext32(ld[31:0]);
            default: val = ld;
          endcase
        end
      end
      rv64x_pkg::OPC_STORE: begin
        if (f3 > 3) ill = 1;
        else begin size = f3[1:0]; addr = a + imms; sdata = b; iss = 1; end
      end
      rv64x_pkg::OPC_OPIMM: begin
        wr = 1;
        case (f3)
          3'd0: val = a + immi;
          3'd1: if (ins[31:26] != 0) ill = 1; else val = a << sh6;
          3'd2: val = {63'h0, $signed(a) < $signed(immi)};
          3'd3: val = {63'h0, a < immi};
          3'd4: val = a ^ immi;
          3'd5: begin
            if (ins[31:26] == 0) val = a >> sh6;
            else if (ins[31:26] == rv64x_pkg::SHI_SRA) val = shr_arith(a, sh6);
            else ill = 1;
          end
          3'd6: val = a | immi;
          default: val = a & immi;
        endcase
      end
      rv64x_pkg::OPC_OPIMMW: begin
        wr = 1;
        if (f3 == 0) val = sext32(a[31:0] + immi[31:0]);
        else if (f3 == 1 && f7 == rv64x_pkg::F7_BASE) val = sext32(a[31:0] << sh5);
        else if (f3 == 5 && f7 == rv64x_pkg::F7_BASE) val = sext32(a[31:0] >> sh5);
        else if (f3 == 5 && f7 == rv64x_pkg::F7_ALT) val = shr_arith(sext32(a[31:0]), sh5);
        else ill = 1;
      end
      rv64x_pkg::OPC_OP: begin
        wr = 1;
        if (f7 == rv64x_pkg::F7_MULDIV) begin
          case (f3)
            3'd0: val = a * b;
            3'd1: begin prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
              val = prod[127:64]; end
            3'd2: begin prod = {{64{a[63]}}, a} * {64'h0, b}; val = prod[127:64]; end
            3'd3: begin prod = {64'h0, a} * {64'h0, b}; val = prod[127:64]; end
            3'd4: val = div_signed(a, b, 0);
            3'd5: val = (b != 0) ? a / b : '1;
            3'd6: val = div_signed(a, b, 1);
            default: val = (b != 0) ? a % b : a;
          endcase
        end else if (f7 == rv64x_pkg::F7_BASE) begin
          case (f3)
            3'd0: val = a + b;
            3'd1: val = a << b[5:0];
            3'd2: val = {63'h0, $signed(a) < $signed(b)};
            3'd3: val = {63'h0, a < b};
            3'd4: val = a ^ b;
            3'd5: val = a >> b[5:0];
            3'd6: val = a | b;
            default: val = a & b;
          endcase
        end else if (f7 == rv64x_pkg::F7_ALT && f3 == 0) val = a - b;
        else if (f7 == rv64x_pkg::F7_ALT && f3 == 5) val = shr_arith(a, b[5:0]);
        else ill = 1;
      end
      rv64x_pkg::OPC_OPW: begin
        wr = 1;
        if (f7 == rv64x_pkg::F7_MULDIV) begin
          case (f3)
            3'd0: val = sext32(a[31:0] * b[31:0]);
            3'd4: val = div_signed32(a[31:0], b[31:0], 0);
            3'd5: val = (b[31:0] != 0) ? sext32(a[31:0] / b[31:0]) : '1;
            3'd6: val = div_signed32(a[31:0], b[31:0], 1);
            3'd7: val = sext32((b[31:0] != 0) ? a[31:0] % b[31:0] : a[31:0]);
            default: ill = 1;
          endcase
        end else if (f7 == rv64x_pkg::F7_BASE && f3 == 0) val = sext32(a[31:0] + b[31:0]);
        else if (f7 == rv64x_pkg::F7_ALT && f3 == 0) val = sext32(a[31:0] - b[31:0]);
        else if (f7 == rv64x_pkg::F7_BASE && f3 == 1) val = sext32(a[31:0] << b[4:0]);
        else if (f7 == rv64x_pkg::F7_BASE && f3 == 5) val = sext32(a[31:0] >> b[4:0]);
        else if (f7 == rv64x_pkg::F7_ALT && f3 == 5)
          val = shr_arith(sext32(a[31:0]), b[4:0]);
        else ill = 1;
      end
      rv64x_pkg::OPC_SYSTEM: sys = 1;
      rv64x_pkg::OPC_FENCE: ;
      default: ill = 1;
    endcase
    if (ill) begin
      wr = 0; isl = 0; iss = 0; npc = pc; val = 0; addr = 0; sdata = 0; size = 0;
    end
    if (wr && rd == 0) wr = 0;
    o.rd_write = wr;
    o.rd_index = wr ? rd : 5'd0;
    o.rd_value = wr ? val : 64'd0;
    o.next_pc = npc;
    o.mem_address = (isl || iss) ? addr : 64'd0;
    o.is_load = isl;
    o.is_store = iss;
    o.store_data = iss ? sdata : 64'd0;
    o.access_size_log2 = (isl || iss) ? size : 2'd0;
    o.illegal = ill;
    o.system_request = sys;
    return o;
  endfunction

  class exec_scoreboard;
    rv64x_pkg::out_word_t pending[$];
    int errors;

    function void note_insn(input rv64x_pkg::in_word_t w);
      pending.push_back(execute_insn(w));
    endfunction

    function void check_result(input rv64x_pkg::out_word_t got);
      rv64x_pkg::out_word_t exp;
      if (pending.size() == 0) begin
        $error("result word with no instruction pending");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.rd_write !== exp.rd_write) begin
        $error("rd_write exp %0h got %0h", exp.rd_write, got.rd_write); errors++; end
      if (got.rd_index !== exp.rd_index) begin
        $error("rd_index exp %0h got %0h", exp.rd_index, got.rd_index); errors++; end
      if (got.rd_value !== exp.rd_value) begin
        $error("rd_value exp %0h got %0h", exp.rd_value, got.rd_value); errors++; end
      if (got.next_pc !== exp.next_pc) begin
        $error("next_pc exp %0h got %0h", exp.next_pc, got.next_pc); errors++; end
      if (got.mem_address !== exp.mem_address) begin
        $error("mem_address exp %0h got %0h", exp.mem_address, got.mem_address); errors++; end
      if (got.is_load !== exp.is_load) begin
        $error("is_load exp %0h got %0h", exp.is_load, got.is_load); errors++; end
      if (got.is_store !== exp.is_store) begin
        $error("is_store exp %0h got %0h", exp.is_store, got.is_store); errors++; end
      if (got.store_data !== exp.store_data) begin
        $error("store_data exp %0h got %0h", exp.store_data, got.store_data); errors++; end
      if (got.access_size_log2 !== exp.access_size_log2) begin
        $error("access_size_log2 exp %0h got %0h", exp.access_size_log2,
               got.access_size_log2); errors++; end
      if (got.illegal !== exp.illegal) begin
        $error("illegal exp %0h got %0h", exp.illegal, got.illegal); errors++; end
      if (got.system_request !== exp.system_request) begin
        $error("system_request exp %0h got %0h", exp.system_request, got.system_request);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  rv64x_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 0;
  rv64x_pkg::out_word_t out_word;

  exec_scoreboard sb = new();
  int cycle_count = 0;
  bit hold_rx = 0;
  bit calm = 0;

  rv64im_execute_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_insn(in_word);
    if (rst_n && out_valid && out_ready) sb.check_result(out_word);
  end

  always @(posedge clk) begin
    if (!rst_n || hold_rx) out_ready <= 0;
    else out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
  end

  function automatic logic [63:0] rand64();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return '1;
      2: return MSB;
      3: return {$urandom_range(3) == 0 ? 32'hFFFF_FFFF : 32'h0, 32'h8000_0000};
      4: return {59'h0, 5'($urandom)};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] rand_insn();
    logic [31:0] ins;
    logic [6:0] ops[13] = '{rv64x_pkg::OPC_LOAD, rv64x_pkg::OPC_FENCE, rv64x_pkg::OPC_OPIMM,
                            rv64x_pkg::OPC_AUIPC, rv64x_pkg::OPC_OPIMMW, rv64x_pkg::OPC_STORE,
                            rv64x_pkg::OPC_OP, rv64x_pkg::OPC_LUI, rv64x_pkg::OPC_OPW,
                            rv64x_pkg::OPC_BRANCH, rv64x_pkg::OPC_JALR, rv64x_pkg::OPC_JAL,
                            rv64x_pkg::OPC_SYSTEM};
    logic [6:0] f7s[3] = '{rv64x_pkg::F7_BASE, rv64x_pkg::F7_MULDIV, rv64x_pkg::F7_ALT};
    ins = $urandom;
    if ($urandom_range(99) < 92) begin
      ins[6:0] = ops[$urandom_range(12)];
      if ($urandom_range(99) < 80 && (ins[6:0] == rv64x_pkg::OPC_OP ||
          ins[6:0] == rv64x_pkg::OPC_OPW || ins[6:0] == rv64x_pkg::OPC_OPIMMW))
        ins[31:25] = f7s[$urandom_range(2)];
      if (ins[6:0] == rv64x_pkg::OPC_OPIMM && $urandom_range(99) < 80)
        ins[31:26] = $urandom_range(1) ? rv64x_pkg::SHI_SRA : 6'h0;
      if (ins[6:0] == rv64x_pkg::OPC_JALR && $urandom_range(99) < 80) ins[14:12] = 3'd0;
      if ($urandom_range(9) == 0) ins[11:7] = 5'd0;
    end
    return ins;
  endfunction

  task automatic send_insn(input rv64x_pkg::in_word_t w);
    in_valid <= 1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic stop_in();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_random(input int n, input bit gaps);
    rv64x_pkg::in_word_t w;
    repeat (n) begin
      if (gaps) begin
        while ($urandom_range(99) < 22) begin
          in_valid <= 0;
          @(posedge clk);
        end
      end
      w.instruction = rand_insn();
      w.pc_value = rand64(); w.rs1_value = rand64(); w.rs2_value = rand64();
      w.load_data = rand64();
      send_insn(w);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic send_directed();
    rv64x_pkg::in_word_t w;
    logic [31:0] dir[$] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_F0B7, 32'h8000_0117, 32'h8000_00EF,
      32'hFFF0_81E7, 32'h0000_1067, 32'hFE20_8EE3, 32'h0020_A463, 32'h0020_F063,
      32'hFFF0_B283, 32'h0000_F303, 32'h0040_4383, 32'hFE20_BFA3, 32'h0020_C023,
      32'h43F0_D413, 32'h0400_9493, 32'h4000_551B, 32'h0220_C5B3, 32'h0220_E633,
      32'h0220_76BB, 32'h0220_173B, 32'h4020_05BB, 32'h0000_0073, 32'h0000_300F};
    foreach (dir[i]) begin
      w.instruction = dir[i];
      w.pc_value = (i % 2) ? '1 : 64'd0;
      w.rs1_value = (i % 3 == 0) ? MSB : ((i % 3 == 1) ? '1 : 64'd0);
      w.rs2_value = (i % 4 == 0) ? '1 : ((i % 4 == 1) ? 64'd0 : MSB);
      w.load_data = (i % 2) ? 64'h0000_0000_8000_8080 : '1;
      send_insn(w);
    end
  endtask

  initial begin
    int hold_len;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_directed();
    send_random(600, 1);
    calm = 1;
    send_random(250, 0);
    calm = 0;
    stop_in();
    drain();
    hold_rx = 1;
    fork
      begin
        hold_len = 0;
        while (hold_len < 300) begin @(posedge clk); hold_len++; end
        hold_rx = 0;
      end
      send_random(60, 0);
    join
    stop_in();
    drain();
    send_random(665, 1);
    stop_in();
    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

[sim.f]
rtl/rv64x_pkg.sv
rtl/rv64x_queue.sv
rtl/rv64x_front.sv
rtl/rv64x_back.sv
rtl/rv64im_execute_unit.sv
sim/rv64im_execute_unit_tb.sv
